>>> sv/mcs_pkg.sv
// shared types and constants of the machine cycle sequencer
`default_nettype none

package mcs_pkg;

    // sample word bit positions, all active low
    localparam int unsigned IN_START_BIT  = 0;
    localparam int unsigned IN_STOP_BIT   = 2;
    localparam int unsigned IN_ENABLE_BIT = 6;
    localparam int unsigned IN_PROG1_BIT  = 8;
    localparam int unsigned IN_PROG2_BIT  = 9;
    localparam int unsigned IN_PROG0_BIT  = 10;
    localparam int unsigned IN_VR_BIT     = 13;
    localparam int unsigned IN_MD2_BIT    = 14;
    localparam int unsigned IN_MD1_BIT    = 15;

    // sensor flag indexes
    localparam int unsigned SNS_MD1 = 0;
    localparam int unsigned SNS_MD2 = 1;
    localparam int unsigned SNS_VR  = 2;
    localparam int unsigned NUM_SNS = 3;

    // drive pattern bits
    localparam logic [7:0] PAT_PP5  = 8'h01;
    localparam logic [7:0] PAT_PP4  = 8'h02;
    localparam logic [7:0] PAT_PP3  = 8'h04;
    localparam logic [7:0] PAT_PP2  = 8'h08;
    localparam logic [7:0] PAT_PP1  = 8'h10;
    localparam logic [7:0] PAT_NET  = 8'h20;
    localparam logic [7:0] PAT_NETR = 8'h80;

    // sequence steps
    localparam logic [3:0] STEP_IDLE = 4'd0;
    localparam logic [3:0] STEP_1    = 4'd1;
    localparam logic [3:0] STEP_2    = 4'd2;
    localparam logic [3:0] STEP_3    = 4'd3;
    localparam logic [3:0] STEP_4    = 4'd4;
    localparam logic [3:0] STEP_5    = 4'd5;
    localparam logic [3:0] STEP_6    = 4'd6;
    localparam logic [3:0] STEP_7    = 4'd7;
    localparam logic [3:0] STEP_8    = 4'd8;
    localparam logic [3:0] STEP_9    = 4'd9;
    localparam logic [3:0] STEP_10   = 4'd10;

    // program codes
    localparam logic [1:0] PROG_0    = 2'd0;
    localparam logic [1:0] PROG_1    = 2'd1;
    localparam logic [1:0] PROG_2    = 2'd2;
    localparam logic [1:0] PROG_NONE = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_START_DELAY      = 3'd0;
    localparam logic [2:0] CFG_EVAC_DELAY       = 3'd1;
    localparam logic [2:0] CFG_EVAC_DELAY_THIRD = 3'd2;
    localparam logic [2:0] CFG_HOLD_DELAY_THIRD = 3'd3;
    localparam logic [2:0] CFG_COOL_DELAY       = 3'd4;
    localparam logic [2:0] CFG_SHORT_DELAY      = 3'd5;
    localparam logic [2:0] CFG_SENSOR_DEBOUNCE  = 3'd6;
    localparam logic [2:0] CFG_BUTTON_DEBOUNCE  = 3'd7;

    // slow update every tenth tick
    localparam logic [3:0] SLOW_TICKS = 4'd10;

    typedef struct packed {
        logic [7:0] start_delay;
        logic [7:0] evac_delay;
        logic [7:0] evac_delay_third;
        logic [7:0] hold_delay_third;
        logic [7:0] cool_delay;
        logic [7:0] short_delay;
        logic [3:0] sensor_debounce;
        logic [2:0] button_debounce;
    } t_cfg;

    typedef struct packed {
        logic [NUM_SNS-1:0] sensor_flags;
        logic [NUM_SNS-1:0] sensor_flags_next;
        logic               start_ev;
        logic               stop_ev;
    } t_dbnc_status;

    typedef struct packed {
        logic [3:0] seq_step;
        logic [1:0] program_sel;
        logic       error_flag;
        logic       work_led;
        logic       led_err;
    } t_seq_status;

endpackage

`default_nettype wire

>>> sv/mcs_debounce.sv
// sensor hysteresis and button debouncers
`default_nettype none

module mcs_debounce (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [15:0]          i_word,
    input  wire logic [3:0]           i_sensor_lim,
    input  wire logic [2:0]           i_button_lim,
    output mcs_pkg::t_dbnc_status     o_status
);

    logic [3:0] r_sns_cnt [mcs_pkg::NUM_SNS];
    logic [3:0] n_sns_cnt [mcs_pkg::NUM_SNS];
    logic [mcs_pkg::NUM_SNS-1:0] r_sns_flag;
    logic [mcs_pkg::NUM_SNS-1:0] n_sns_flag;
    logic [mcs_pkg::NUM_SNS-1:0] sns_active;
    logic [2:0] r_start_cnt, n_start_cnt;
    logic [2:0] r_stop_cnt, n_stop_cnt;
    logic       start_ev, stop_ev;

    assign sns_active[mcs_pkg::SNS_MD1] = ~i_word[mcs_pkg::IN_MD1_BIT];
    assign sns_active[mcs_pkg::SNS_MD2] = ~i_word[mcs_pkg::IN_MD2_BIT];
    assign sns_active[mcs_pkg::SNS_VR]  = ~i_word[mcs_pkg::IN_VR_BIT];

    // up/down count with flag set at the limit and cleared at zero
    always_comb begin
        for (int i = 0; i < mcs_pkg::NUM_SNS; i++) begin
            n_sns_cnt[i]  = r_sns_cnt[i];
            n_sns_flag[i] = r_sns_flag[i];
            if (sns_active[i]) begin
                if (r_sns_cnt[i] < i_sensor_lim) begin
                    n_sns_cnt[i] = r_sns_cnt[i] + 4'd1;
                    if (n_sns_cnt[i] == i_sensor_lim) n_sns_flag[i] = 1'b1;
                end
            end else if (r_sns_cnt[i] != 4'd0) begin
                n_sns_cnt[i] = r_sns_cnt[i] - 4'd1;
                if (n_sns_cnt[i] == 4'd0) n_sns_flag[i] = 1'b0;
            end
        end
    end

    // buttons fire once when the pressed count reaches the limit
    always_comb begin
        n_start_cnt = r_start_cnt;
        start_ev    = 1'b0;
        if (i_word[mcs_pkg::IN_START_BIT]) begin
            n_start_cnt = 3'd0;
        end else if (r_start_cnt < i_button_lim) begin
            n_start_cnt = r_start_cnt + 3'd1;
            start_ev    = (n_start_cnt >= i_button_lim);
        end

        n_stop_cnt = r_stop_cnt;
        stop_ev    = 1'b0;
        if (i_word[mcs_pkg::IN_STOP_BIT]) begin
            n_stop_cnt = 3'd0;
        end else if (r_stop_cnt < i_button_lim) begin
            n_stop_cnt = r_stop_cnt + 3'd1;
            stop_ev    = (n_stop_cnt >= i_button_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mcs_pkg::NUM_SNS; i++) r_sns_cnt[i] <= 4'd0;
            r_sns_flag  <= '0;
            r_start_cnt <= 3'd0;
            r_stop_cnt  <= 3'd0;
        end else if (i_en) begin
            for (int i = 0; i < mcs_pkg::NUM_SNS; i++) r_sns_cnt[i] <= n_sns_cnt[i];
            r_sns_flag  <= n_sns_flag;
            r_start_cnt <= n_start_cnt;
            r_stop_cnt  <= n_stop_cnt;
        end
    end

    assign o_status.sensor_flags      = r_sns_flag;
    assign o_status.sensor_flags_next = n_sns_flag;
    assign o_status.start_ev          = start_ev;
    assign o_status.stop_ev           = stop_ev;

endmodule

`default_nettype wire

>>> sv/mcs_seq.sv
// step sequencer, delay counter and slow status update
`default_nettype none

module mcs_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic [15:0]          i_word,
    input  wire mcs_pkg::t_cfg        i_cfg,
    input  wire mcs_pkg::t_dbnc_status i_dbnc,
    output logic [7:0]                o_pattern,
    output mcs_pkg::t_seq_status      o_next
);

    logic [3:0] r_step, n_step;
    logic [1:0] r_program, n_program;
    logic [7:0] r_delay, n_delay;
    logic [3:0] r_div, n_div;
    logic       r_error, n_error;
    logic       r_work_led, n_work_led;
    logic       r_led_err, n_led_err;

    logic [7:0] dec;
    logic       done;
    logic [7:0] evac;
    logic [7:0] pat;
    logic       enable, md1, md2, vr;
    logic [3:0] div_inc;
    logic       slow, idle;
    logic       p0, p1, p2;

    assign enable = ~i_word[mcs_pkg::IN_ENABLE_BIT];
    assign md1    = i_dbnc.sensor_flags[mcs_pkg::SNS_MD1];
    assign md2    = i_dbnc.sensor_flags[mcs_pkg::SNS_MD2];
    assign vr     = i_dbnc.sensor_flags[mcs_pkg::SNS_VR];
    assign dec    = r_delay - 8'd1;
    assign done   = (dec == 8'd0);
    assign evac   = (r_program == mcs_pkg::PROG_2) ? i_cfg.evac_delay_third
                                                   : i_cfg.evac_delay;

    always_comb begin
        n_step  = r_step;
        n_delay = r_delay;
        pat     = 8'h00;

        priority if (r_program == mcs_pkg::PROG_NONE) begin
            pat = 8'h00;
        end else if (r_step == mcs_pkg::STEP_1) begin
            pat     = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP2;
            n_delay = dec;
            if (done) begin
                if (enable) begin
                    n_step  = mcs_pkg::STEP_3;
                    n_delay = evac;
                end else begin
                    n_step = mcs_pkg::STEP_2;
                end
            end
        end else if (r_step == mcs_pkg::STEP_2) begin
            pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP2 | mcs_pkg::PAT_PP3;
            if (vr) begin
                n_step  = mcs_pkg::STEP_3;
                n_delay = evac;
            end
        end else if (r_program == mcs_pkg::PROG_0) begin
            unique case (r_step)
                mcs_pkg::STEP_3: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_NET
                        | mcs_pkg::PAT_NETR;
                    n_delay = dec;
                    if (done) n_step = mcs_pkg::STEP_4;
                end
                mcs_pkg::STEP_4: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP4
                        | mcs_pkg::PAT_NET | mcs_pkg::PAT_NETR;
                    if (md1) begin
                        n_step  = mcs_pkg::STEP_5;
                        n_delay = i_cfg.short_delay;
                    end
                end
                mcs_pkg::STEP_5: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP4
                        | mcs_pkg::PAT_NET | mcs_pkg::PAT_NETR;
                    n_delay = dec;
                    if (done) n_step = mcs_pkg::STEP_6;
                end
                mcs_pkg::STEP_6: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP5
                        | mcs_pkg::PAT_NET | mcs_pkg::PAT_NETR;
                    if (md2) begin
                        n_step  = mcs_pkg::STEP_7;
                        n_delay = i_cfg.short_delay;
                    end
                end
                mcs_pkg::STEP_7: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP5
                        | mcs_pkg::PAT_NET | mcs_pkg::PAT_NETR;
                    n_delay = done ? i_cfg.short_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_8;
                end
                mcs_pkg::STEP_8: begin
                    pat     = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3;
                    n_delay = done ? i_cfg.cool_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_9;
                end
                mcs_pkg::STEP_9: begin
                    pat     = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP2;
                    n_delay = done ? i_cfg.short_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_10;
                end
                mcs_pkg::STEP_10: begin
                    pat     = mcs_pkg::PAT_PP2;
                    n_delay = dec;
                    if (done) n_step = mcs_pkg::STEP_IDLE;
                end
                default: begin
                    pat = 8'h00;
                end
            endcase
        end else if (r_program == mcs_pkg::PROG_1) begin
            unique case (r_step)
                mcs_pkg::STEP_3: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_NET
                        | mcs_pkg::PAT_NETR;
                    n_delay = dec;
                    if (done) n_step = mcs_pkg::STEP_4;
                end
                mcs_pkg::STEP_4: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP4
                        | mcs_pkg::PAT_NET | mcs_pkg::PAT_NETR;
                    if (md1) begin
                        n_step  = mcs_pkg::STEP_5;
                        n_delay = i_cfg.short_delay;
                    end
                end
                mcs_pkg::STEP_5: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP4
                        | mcs_pkg::PAT_NET | mcs_pkg::PAT_NETR;
                    n_delay = done ? i_cfg.short_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_6;
                end
                mcs_pkg::STEP_6: begin
                    pat     = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3;
                    n_delay = done ? i_cfg.cool_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_7;
                end
                mcs_pkg::STEP_7: begin
                    pat     = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP2;
                    n_delay = done ? i_cfg.short_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_8;
                end
                mcs_pkg::STEP_8: begin
                    pat     = mcs_pkg::PAT_PP2;
                    n_delay = dec;
                    if (done) n_step = mcs_pkg::STEP_IDLE;
                end
                default: begin
                    pat = 8'h00;
                end
            endcase
        end else begin
            // third program
            unique case (r_step)
                mcs_pkg::STEP_3: begin
                    pat     = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3;
                    n_delay = done ? i_cfg.hold_delay_third : dec;
                    if (done) n_step = mcs_pkg::STEP_4;
                end
                mcs_pkg::STEP_4: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP3 | mcs_pkg::PAT_PP4
                        | mcs_pkg::PAT_PP5;
                    n_delay = done ? i_cfg.cool_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_5;
                end
                mcs_pkg::STEP_5: begin
                    pat = mcs_pkg::PAT_PP1 | mcs_pkg::PAT_PP2 | mcs_pkg::PAT_PP4
                        | mcs_pkg::PAT_PP5;
                    n_delay = done ? i_cfg.short_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_6;
                end
                mcs_pkg::STEP_6: begin
                    pat     = mcs_pkg::PAT_PP2 | mcs_pkg::PAT_PP4 | mcs_pkg::PAT_PP5;
                    n_delay = done ? i_cfg.short_delay : dec;
                    if (done) n_step = mcs_pkg::STEP_7;
                end
                mcs_pkg::STEP_7: begin
                    pat     = mcs_pkg::PAT_PP2;
                    n_delay = dec;
                    if (done) n_step = mcs_pkg::STEP_IDLE;
                end
                default: begin
                    pat = 8'h00;
                end
            endcase
        end

        // start only from idle without error, stop wins
        if (i_dbnc.start_ev && (n_step == mcs_pkg::STEP_IDLE) && !r_error) begin
            n_step = mcs_pkg::STEP_1;
            if (r_program != mcs_pkg::PROG_NONE) n_delay = i_cfg.start_delay;
        end
        if (i_dbnc.stop_ev) n_step = mcs_pkg::STEP_IDLE;
    end

    assign o_pattern = enable ? (pat & ~mcs_pkg::PAT_PP3) : pat;

    assign div_inc = r_div + 4'd1;
    assign slow    = (div_inc == mcs_pkg::SLOW_TICKS);
    assign idle    = (n_step == mcs_pkg::STEP_IDLE);
    assign p0      = ~i_word[mcs_pkg::IN_PROG0_BIT];
    assign p1      = ~i_word[mcs_pkg::IN_PROG1_BIT];
    assign p2      = ~i_word[mcs_pkg::IN_PROG2_BIT];

    always_comb begin
        n_div      = div_inc;
        n_error    = r_error;
        n_work_led = r_work_led;
        n_led_err  = r_led_err;
        n_program  = r_program;
        if (slow) begin
            n_div      = 4'd0;
            n_work_led = idle;
            n_led_err  = ~(idle & r_error);
            n_error    = idle & (|i_dbnc.sensor_flags_next);
            priority if (p0 && !p1 && !p2) n_program = mcs_pkg::PROG_0;
            else if (p1 && !p0 && !p2)     n_program = mcs_pkg::PROG_1;
            else if (p2 && !p0 && !p1)     n_program = mcs_pkg::PROG_2;
            else                           n_program = mcs_pkg::PROG_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= mcs_pkg::STEP_IDLE;
            r_program  <= mcs_pkg::PROG_0;
            r_delay    <= 8'd0;
            r_div      <= 4'd0;
            r_error    <= 1'b0;
            r_work_led <= 1'b0;
            r_led_err  <= 1'b0;
        end else if (i_en) begin
            r_step     <= n_step;
            r_program  <= n_program;
            r_delay    <= n_delay;
            r_div      <= n_div;
            r_error    <= n_error;
            r_work_led <= n_work_led;
            r_led_err  <= n_led_err;
        end
    end

    assign o_next.seq_step    = n_step;
    assign o_next.program_sel = n_program;
    assign o_next.error_flag  = n_error;
    assign o_next.work_led    = n_work_led;
    assign o_next.led_err     = n_led_err;

endmodule

`default_nettype wire

>>> sv/machine_cycle_sequencer_top.sv
// top level of the machine cycle sequencer
`default_nettype none

// Each input transaction is one 100 Hz tick carrying the sampled, active-low
// input word; each tick yields exactly one output transaction with the drive
// pattern for the valves and contactors, the LED bits, the step after the
// tick (zero is idle), the selected program (three is none) and the error
// flag. The tick is held in an input register; the step logic, delay down
// counter, sensor hysteresis, button debouncers and the every-tenth-tick
// status update all sit in one combinational pass from that register into
// the sequencer state and the output register. The result passes two register
// stages, the input register and then the output register, and a new tick is
// accepted every cycle; the output register decouples the sides, so the input
// stalls only when a result waits in the output register and another waits in
// the input register. Delay and debounce registers are written through the
// plain write port and must be changed only while no tick is in flight.
module machine_cycle_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_word
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] drive_pattern, [8] work_led,
                                             // [9] led_err, [13:10] seq_step,
                                             // [15:14] program_sel, [16] error_flag,
                                             // [23:17] zero
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_wdata
);

    mcs_pkg::t_cfg         r_cfg;
    mcs_pkg::t_dbnc_status dbnc;
    mcs_pkg::t_seq_status  seq_next;

    logic        r_in_valid;
    logic [15:0] r_in_word;
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        advance;
    logic        tick_en;
    logic [7:0]  pattern;

    // output register free or being drained this cycle
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    // one tick of sequencer state per transaction moved to the output
    assign tick_en       = r_in_valid && advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_delay      <= 8'd50;
            r_cfg.evac_delay       <= 8'd30;
            r_cfg.evac_delay_third <= 8'd80;
            r_cfg.hold_delay_third <= 8'd120;
            r_cfg.cool_delay       <= 8'd150;
            r_cfg.short_delay      <= 8'd30;
            r_cfg.sensor_debounce  <= 4'd10;
            r_cfg.button_debounce  <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcs_pkg::CFG_START_DELAY:      r_cfg.start_delay      <= i_cfg_wdata;
                mcs_pkg::CFG_EVAC_DELAY:       r_cfg.evac_delay       <= i_cfg_wdata;
                mcs_pkg::CFG_EVAC_DELAY_THIRD: r_cfg.evac_delay_third <= i_cfg_wdata;
                mcs_pkg::CFG_HOLD_DELAY_THIRD: r_cfg.hold_delay_third <= i_cfg_wdata;
                mcs_pkg::CFG_COOL_DELAY:       r_cfg.cool_delay       <= i_cfg_wdata;
                mcs_pkg::CFG_SHORT_DELAY:      r_cfg.short_delay      <= i_cfg_wdata;
                mcs_pkg::CFG_SENSOR_DEBOUNCE:  r_cfg.sensor_debounce  <= i_cfg_wdata[3:0];
                mcs_pkg::CFG_BUTTON_DEBOUNCE:  r_cfg.button_debounce  <= i_cfg_wdata[2:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata;
        end
    end

    mcs_debounce u_debounce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (tick_en),
        .i_word       (r_in_word),
        .i_sensor_lim (r_cfg.sensor_debounce),
        .i_button_lim (r_cfg.button_debounce),
        .o_status     (dbnc)
    );

    mcs_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (tick_en),
        .i_word    (r_in_word),
        .i_cfg     (r_cfg),
        .i_dbnc    (dbnc),
        .o_pattern (pattern),
        .o_next    (seq_next)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_en) begin
            r_out_data <= {7'd0, seq_next.error_flag, seq_next.program_sel,
                           seq_next.seq_step, seq_next.led_err, seq_next.work_led,
                           pattern};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> sv/mcs_checker.sv
// port-level checker for the machine cycle sequencer and its bind
`default_nettype none

module mcs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    // step never beyond the longest program
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[13:10] <= 4'd10)
        else $error("step out of range");

    // error is only raised while idle and blocks start
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[13:10] == 4'd0)
        else $error("error flag set outside idle");

    // padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
        else $error("padding bits not zero");

    // input is never refused while the output register is empty
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind machine_cycle_sequencer_top mcs_checker u_mcs_checker (.*);

`default_nettype wire
